/* hw/rtl/slrmq_pkg.sv */
// Shared constants, payload types and control interface types for the LCP range-minimum block.
`default_nettype none

package slrmq_pkg;

  localparam int MAX_SUFFIXES = 4096;
  localparam int TABLE_LEVELS = 13;

  localparam int IDX_W       = $clog2(MAX_SUFFIXES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int LEVEL_W     = $clog2(TABLE_LEVELS + 1);
  localparam int LOG_W       = $clog2(IDX_W);
  localparam int TAB_ADDR_W  = LEVEL_W + IDX_W;
  localparam int TAB_DEPTH   = TABLE_LEVELS * MAX_SUFFIXES;
  localparam int HEIGHT_W    = 13;
  localparam int CFG_W       = 13;
  localparam int REQ_W       = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD  = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_BUILD = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_QUERY = REQ_W'(2);

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [IDX_W-1:0]    index_a;
    logic [IDX_W-1:0]    index_b;
    logic [IDX_W-1:0]    rank_value;
    logic [HEIGHT_W-1:0] height_value;
  } slrmq_req_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] lcp_length;
    logic                status;
  } slrmq_rsp_t;

  typedef struct packed {
    logic accept;
    logic load_wr;
    logic build_start;
    logic next_level;
    logic build_wr;
    logic set_built;
    logic rank_eval;
    logic tab_query;
    logic min_eval;
    logic resp_load;
  } slrmq_cmd_t;

  typedef struct packed {
    logic level_ok;
    logic entry_ok;
    logic out_free;
  } slrmq_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/suffix_lcp_range_min_query_core.sv */
// A query word steps through the rank, table-read and minimum states, a load through one write
// state, and a spare code goes straight to the response state. One word is handled at a time.
// A build sweeps each higher table level entry by entry through the shared table memory ports,
// checking each entry and then writing it, and steps to the next level when a level is done.
// Reset clears the controller, the response valid and the built flag; live_count
// returns to 2. The memories are not cleared and must be loaded before use.
`default_nettype none

// Top level of the LCP range-minimum query engine.
//
// The block keeps two memories. The rank memory maps a suffix position to its rank
// in the suffix array. The range-minimum memory holds one row of heights per sparse
// table level; level zero is the adjacent-suffix LCP array written by load words,
// and each higher level holds the minimum over a window twice as wide as the level
// below. A build word sweeps the levels in order, reading two entries of the level
// below on the dual read ports and writing their minimum on the next cycle.
//
// A query word reads both ranks in the cycle it is accepted, orders them, picks the
// window exponent from the span, then reads the two overlapping windows that cover
// the rank interval and returns their minimum. Equal positions, positions or ranks
// beyond the live suffix count, equal ranks and queries before a completed build
// are flagged with status set and a zero length.
//
// The response register decouples the two sides: a new word may be accepted while
// the previous response still waits to be taken.
module suffix_lcp_range_min_query_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [slrmq_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire slrmq_pkg::slrmq_req_t        req_data,
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output slrmq_pkg::slrmq_rsp_t             rsp_data
);

  localparam int CNT_W = slrmq_pkg::CNT_W;

  slrmq_pkg::slrmq_cmd_t  cmd;
  slrmq_pkg::slrmq_stat_t stat;

  // The suffix count is held already clamped to the usable range of two up to the
  // memory depth, so the datapath compares against it directly.
  logic [CNT_W-1:0] live_count;
  logic [CNT_W-1:0] live_count_next;

  always_comb begin
    if (int'(cfg_data) < 2) begin
      live_count_next = CNT_W'(2);
    end else if (int'(cfg_data) > slrmq_pkg::MAX_SUFFIXES) begin
      live_count_next = CNT_W'(slrmq_pkg::MAX_SUFFIXES);
    end else begin
      live_count_next = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= CNT_W'(2);
    end else if (cfg_we) begin
      live_count <= live_count_next;
    end
  end

  // The controller only sees the request code; the datapath captures the rest of
  // the word on acceptance.
  slrmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_data.req_type),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slrmq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_data   (req_data),
    .live_count (live_count),
    .rsp_ready  (rsp_ready),
    .rsp_valid  (rsp_valid),
    .rsp_data   (rsp_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/slrmq_ram.sv */
// Generic single-write, dual-read memory with registered read data.
`default_nettype none

module slrmq_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8,
  parameter int DEPTH  = 256
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr_a,
  input  wire logic [ADDR_W-1:0] rd_addr_b,
  output logic      [DATA_W-1:0] rd_data_a,
  output logic      [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

/* hw/rtl/slrmq_ctrl.sv */
// Controller state machine that sequences loads, table builds and queries.
`default_nettype none

module slrmq_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  input  wire logic [slrmq_pkg::REQ_W-1:0] req_type,
  output logic                            req_ready,
  input  wire slrmq_pkg::slrmq_stat_t     stat,
  output slrmq_pkg::slrmq_cmd_t           cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_BUILD_CHK,
    S_BUILD_WR,
    S_Q_RANK,
    S_Q_READ,
    S_Q_MIN,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          unique case (req_type)
            slrmq_pkg::REQ_LOAD:  state_next = S_LOAD;
            slrmq_pkg::REQ_BUILD: begin
              cmd.build_start = 1'b1;
              state_next      = S_BUILD_CHK;
            end
            slrmq_pkg::REQ_QUERY: state_next = S_Q_RANK;
            default:              state_next = S_RESP;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next  = S_RESP;
      end
      S_BUILD_CHK: begin
        if (!stat.level_ok) begin
          cmd.set_built = 1'b1;
          state_next    = S_RESP;
        end else if (!stat.entry_ok) begin
          cmd.next_level = 1'b1;
        end else begin
          state_next = S_BUILD_WR;
        end
      end
      S_BUILD_WR: begin
        cmd.build_wr = 1'b1;
        state_next   = S_BUILD_CHK;
      end
      S_Q_RANK: begin
        cmd.rank_eval = 1'b1;
        state_next    = S_Q_READ;
      end
      S_Q_READ: begin
        cmd.tab_query = 1'b1;
        state_next    = S_Q_MIN;
      end
      S_Q_MIN: begin
        cmd.min_eval = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/slrmq_datapath.sv */
// Datapath: rank and range-minimum memories, build counters, query arithmetic, output register.
`default_nettype none

module slrmq_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire slrmq_pkg::slrmq_cmd_t            cmd,
  output slrmq_pkg::slrmq_stat_t                stat,
  input  wire slrmq_pkg::slrmq_req_t            req_data,
  input  wire logic [slrmq_pkg::CNT_W-1:0]      live_count,
  input  wire logic                             rsp_ready,
  output logic                                  rsp_valid,
  output slrmq_pkg::slrmq_rsp_t                 rsp_data
);

  localparam int IDX_W    = slrmq_pkg::IDX_W;
  localparam int CNT_W    = slrmq_pkg::CNT_W;
  localparam int LEVEL_W  = slrmq_pkg::LEVEL_W;
  localparam int LOG_W    = slrmq_pkg::LOG_W;
  localparam int HEIGHT_W = slrmq_pkg::HEIGHT_W;
  localparam int TAB_AW   = slrmq_pkg::TAB_ADDR_W;

  // Position of the highest set bit; zero for an input of zero or one.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [IDX_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int b = 0; b < IDX_W; b++) begin
      if (v[b]) begin
        r = LOG_W'(b);
      end
    end
    return r;
  endfunction

  // Captured word.
  logic [IDX_W-1:0]    pos_a;
  logic [IDX_W-1:0]    pos_b;
  logic [IDX_W-1:0]    rank_in;
  logic [HEIGHT_W-1:0] height_in;

  logic                built;
  logic [LEVEL_W-1:0]  level;
  logic [IDX_W-1:0]    entry;

  logic [IDX_W-1:0]    q_lo;
  logic [IDX_W-1:0]    q_hi;
  logic [LEVEL_W-1:0]  q_level;
  logic                q_flag;

  logic [HEIGHT_W-1:0] res_len;
  logic                res_status;

  logic [IDX_W-1:0]    rank_a;
  logic [IDX_W-1:0]    rank_b;
  logic [HEIGHT_W-1:0] tab_a;
  logic [HEIGHT_W-1:0] tab_b;
  logic [HEIGHT_W-1:0] min_ab;

  logic                tab_wr_en;
  logic [TAB_AW-1:0]   tab_wr_addr;
  logic [HEIGHT_W-1:0] tab_wr_data;
  logic [TAB_AW-1:0]   tab_rd_a;
  logic [TAB_AW-1:0]   tab_rd_b;

  logic [CNT_W:0]      pow_level;
  logic [CNT_W:0]      half_level;
  logic [CNT_W+1:0]    entry_end;
  logic [LEVEL_W-1:0]  level_below;

  logic [IDX_W-1:0]    rank_min;
  logic [IDX_W-1:0]    rank_max;
  logic [IDX_W-1:0]    span;
  logic [LOG_W-1:0]    k_raw;
  logic [LEVEL_W-1:0]  k_sel;
  logic                flag;
  logic [CNT_W-1:0]    q_start_wide;
  logic [IDX_W-1:0]    q_start;

  slrmq_ram #(
    .DATA_W (IDX_W),
    .ADDR_W (IDX_W),
    .DEPTH  (slrmq_pkg::MAX_SUFFIXES)
  ) u_rank_ram (
    .clk       (clk),
    .wr_en     (cmd.load_wr),
    .wr_addr   (pos_a),
    .wr_data   (rank_in),
    .rd_addr_a (req_data.index_a),
    .rd_addr_b (req_data.index_b),
    .rd_data_a (rank_a),
    .rd_data_b (rank_b)
  );

  slrmq_ram #(
    .DATA_W (HEIGHT_W),
    .ADDR_W (TAB_AW),
    .DEPTH  (slrmq_pkg::TAB_DEPTH)
  ) u_table_ram (
    .clk       (clk),
    .wr_en     (tab_wr_en),
    .wr_addr   (tab_wr_addr),
    .wr_data   (tab_wr_data),
    .rd_addr_a (tab_rd_a),
    .rd_addr_b (tab_rd_b),
    .rd_data_a (tab_a),
    .rd_data_b (tab_b)
  );

  assign min_ab = (tab_a < tab_b) ? tab_a : tab_b;

  // Build sweep bounds for the current level.
  assign pow_level   = (CNT_W+1)'(1) << level;
  assign half_level  = pow_level >> 1;
  assign entry_end   = {3'b000, entry} + {1'b0, pow_level};
  assign level_below = level - LEVEL_W'(1);

  assign stat.level_ok = (level < LEVEL_W'(slrmq_pkg::TABLE_LEVELS)) &&
                         (pow_level <= {1'b0, live_count});
  assign stat.entry_ok = entry_end <= {2'b00, live_count};
  assign stat.out_free = !rsp_valid || rsp_ready;

  // Query rank ordering and window exponent.
  assign rank_min = (rank_a < rank_b) ? rank_a : rank_b;
  assign rank_max = (rank_a < rank_b) ? rank_b : rank_a;
  assign span     = rank_max - rank_min;
  assign k_raw    = floor_log2(span);

  always_comb begin
    if (int'(k_raw) > slrmq_pkg::TABLE_LEVELS - 1) begin
      k_sel = LEVEL_W'(slrmq_pkg::TABLE_LEVELS - 1);
    end else begin
      k_sel = LEVEL_W'(k_raw);
    end
  end

  assign flag = !built || (pos_a == pos_b) ||
                ({1'b0, pos_a} >= live_count) || ({1'b0, pos_b} >= live_count) ||
                (rank_a == rank_b) ||
                ({1'b0, rank_a} >= live_count) || ({1'b0, rank_b} >= live_count);

  assign q_start_wide = {1'b0, q_hi} + CNT_W'(1) - (CNT_W'(1) << q_level);
  assign q_start      = q_start_wide[IDX_W-1:0];

  // Table port selection: loads write level zero, the build writes the level it sweeps.
  assign tab_wr_en   = cmd.load_wr || cmd.build_wr;
  assign tab_wr_addr = cmd.load_wr ? {LEVEL_W'(0), pos_a} : {level, entry};
  assign tab_wr_data = cmd.load_wr ? height_in : min_ab;
  assign tab_rd_a    = cmd.tab_query ? {q_level, q_lo}    : {level_below, entry};
  assign tab_rd_b    = cmd.tab_query ? {q_level, q_start} :
                                       {level_below, entry + half_level[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_a     <= req_data.index_a;
      pos_b     <= req_data.index_b;
      rank_in   <= req_data.rank_value;
      height_in <= req_data.height_value;
    end
    if (cmd.build_start) begin
      level <= LEVEL_W'(1);
      entry <= IDX_W'(1);
    end else if (cmd.next_level) begin
      level <= level + LEVEL_W'(1);
      entry <= IDX_W'(1);
    end else if (cmd.build_wr) begin
      entry <= entry + IDX_W'(1);
    end
    if (cmd.rank_eval) begin
      q_lo    <= rank_min + IDX_W'(1);
      q_hi    <= rank_max;
      q_level <= k_sel;
      q_flag  <= flag;
    end
    if (cmd.accept) begin
      res_len    <= '0;
      res_status <= 1'b0;
    end else if (cmd.min_eval) begin
      res_len    <= q_flag ? '0 : min_ab;
      res_status <= q_flag;
    end
    if (cmd.resp_load) begin
      rsp_data.lcp_length <= res_len;
      rsp_data.status     <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      built     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.load_wr) begin
        built <= 1'b0;
      end else if (cmd.set_built) begin
        built <= 1'b1;
      end
      if (cmd.resp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/slrmq_port_check.sv */
// Port-level assertions for the LCP range-minimum block and their binding.
`default_nettype none

module slrmq_port_check (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  req_valid,
  input wire logic                  req_ready,
  input wire logic                  rsp_valid,
  input wire logic                  rsp_ready,
  input wire slrmq_pkg::slrmq_rsp_t rsp_data
);

  // One word at a time: the block is busy in the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request side still ready right after an accepted word");

  // No response can appear in the cycle straight after a word is taken.
  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !$rose(rsp_valid))
    else $error("response rose one cycle after acceptance");

  // A flagged response never carries a length.
  a_flag_zero_len: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status) |-> (rsp_data.lcp_length == '0))
    else $error("flagged response with non-zero length");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled response dropped or changed");

  // Reset empties the response register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind suffix_lcp_range_min_query_core slrmq_port_check u_port_check (.*);

`default_nettype wire
